// ===== src/rdsc_pkg.sv =====
package rdsc_pkg;

	localparam int VALUE_BITS_DEF   = 32;
	localparam int GROUP_DIGITS_DEF = 3;

	localparam int BASE_W = 6;
	localparam int CHAR_W = 7;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;
	localparam logic [BASE_W-1:0] DEC_DIGITS = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 7'h20;

	typedef logic [BASE_W-1:0] digit_t;
	typedef logic [CHAR_W-1:0] char_t;

	function automatic char_t digit_char(input digit_t d);
		char_t c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + {1'b0, d};
		end else begin
			c = CHAR_A + {1'b0, d - DEC_DIGITS};
		end
		return c;
	endfunction

endpackage

// ===== src/radix_digit_string_converter_unit.sv =====
// Unsigned integer to ASCII digit string, base 2 to 36.
// Input channel: value and base, taken when in_valid is high and in_stall low.
// in_stall is high from the accepted transaction until its last character is
// loaded into the output register; one number is converted at a time.
// Base values below 2 act as 2, above 36 act as 36.
// Output channel: one transaction per character, most significant digit
// first, '0'-'9' then 'A'-'Z', a space between digit groups counted from the
// least significant end; last marks the final character. Zero gives "0".
// Digits come from a shared restoring divider, one quotient bit per cycle;
// each remainder is written to a small memory. The digits are then read back
// most significant first: a registered memory read, then a load into the
// output register; each space takes its own sequencer state.
// When out_stall is high while a character is valid, the output register holds
// and the sequencer waits in its digit or space state. Reset clears the
// sequencer and the output valid; no data is kept across numbers.
module radix_digit_string_converter_unit #(
	parameter int VALUE_BITS   = rdsc_pkg::VALUE_BITS_DEF,
	parameter int GROUP_DIGITS = rdsc_pkg::GROUP_DIGITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] value,
	input  rdsc_pkg::digit_t      base,
	output logic                  out_valid,
	input  logic                  out_stall,
	output rdsc_pkg::char_t       character,
	output logic                  last
);

	localparam int IDX_W = $clog2(VALUE_BITS);
	localparam int GRP_W = $clog2(GROUP_DIGITS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV  = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_DIG  = 3'd3;
	localparam logic [2:0] S_SPC  = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] idx_q;
	logic [GRP_W-1:0] grp_q;
	rdsc_pkg::digit_t base_q;

	logic                  out_valid_q;
	rdsc_pkg::char_t       char_q;
	logic                  last_q;

	logic                  accept;
	logic                  out_free;
	rdsc_pkg::digit_t      base_sat;
	logic                  div_start;
	logic [VALUE_BITS-1:0] div_dividend;
	rdsc_pkg::digit_t      div_divisor;
	logic                  div_done;
	logic [VALUE_BITS-1:0] div_quot;
	rdsc_pkg::digit_t      div_rem;
	rdsc_pkg::digit_t      rd_digit;
	logic                  more;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign more     = (div_quot != '0);

	always_comb begin
		priority if (base < rdsc_pkg::BASE_MIN) begin
			base_sat = rdsc_pkg::BASE_MIN;
		end else if (base > rdsc_pkg::BASE_MAX) begin
			base_sat = rdsc_pkg::BASE_MAX;
		end else begin
			base_sat = base;
		end
	end

	assign div_start    = accept || (state_q == S_DIV && div_done && more);
	assign div_dividend = accept ? value : div_quot;
	assign div_divisor  = accept ? base_sat : base_q;

	rdsc_divider #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	rdsc_digit_mem #(
		.DEPTH(VALUE_BITS)
	) u_mem (
		.clk     (clk),
		.wr_en   (state_q == S_DIV && div_done),
		.wr_addr (idx_q),
		.wr_data (div_rem),
		.rd_addr (idx_q),
		.rd_data (rd_digit)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			idx_q       <= '0;
			grp_q       <= '0;
			base_q      <= rdsc_pkg::BASE_MIN;
			out_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						base_q  <= base_sat;
						idx_q   <= '0;
						grp_q   <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (more) begin
							idx_q <= idx_q + 1'b1;
							if (grp_q == GRP_W'(GROUP_DIGITS - 1)) begin
								grp_q <= '0;
							end else begin
								grp_q <= grp_q + 1'b1;
							end
						end else begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					state_q <= S_DIG;
				end
				S_DIG: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (idx_q == '0) begin
							state_q <= S_IDLE;
						end else if (grp_q == '0) begin
							state_q <= S_SPC;
						end else begin
							idx_q   <= idx_q - 1'b1;
							grp_q   <= grp_q - 1'b1;
							state_q <= S_RD;
						end
					end
				end
				S_SPC: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						idx_q       <= idx_q - 1'b1;
						grp_q       <= GRP_W'(GROUP_DIGITS - 1);
						state_q     <= S_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == S_DIG) begin
				char_q <= rdsc_pkg::digit_char(rd_digit);
				last_q <= (idx_q == '0);
			end else if (state_q == S_SPC) begin
				char_q <= rdsc_pkg::CHAR_SPACE;
				last_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

`ifndef ASSERT_OFF
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("divider finished outside the divide phase");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == S_DIV && !div_done)
		else $error("accepted transaction did not start a division");

	a_final_digit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIG && out_free && idx_q == '0) |=>
			(state_q == S_IDLE && out_valid && last))
		else $error("final digit not flagged or sequencer not idle");

	a_space_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SPC && out_free) |=>
			(out_valid && !last && character == rdsc_pkg::CHAR_SPACE))
		else $error("group space emitted as last or wrong code");
`endif

endmodule

// ===== src/rdsc_divider.sv =====
module rdsc_divider #(
	parameter int VALUE_BITS = rdsc_pkg::VALUE_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [VALUE_BITS-1:0]   dividend,
	input  rdsc_pkg::digit_t        divisor,
	output logic                    done,
	output logic [VALUE_BITS-1:0]   quotient,
	output rdsc_pkg::digit_t        remainder
);

	localparam int CNT_W = $clog2(VALUE_BITS);

	logic                    busy_q;
	logic                    done_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [VALUE_BITS-1:0]   dvd_q;
	rdsc_pkg::digit_t        div_q;
	rdsc_pkg::digit_t        rem_q;

	logic [rdsc_pkg::BASE_W:0] rem_sh;
	logic [rdsc_pkg::BASE_W:0] diff;
	logic                      ge;

	assign rem_sh = {rem_q, dvd_q[VALUE_BITS-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign diff   = rem_sh - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(VALUE_BITS - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[VALUE_BITS-2:0], ge};
			rem_q <= ge ? diff[rdsc_pkg::BASE_W-1:0] : rem_sh[rdsc_pkg::BASE_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = dvd_q;
	assign remainder = rem_q;

endmodule

// ===== src/rdsc_digit_mem.sv =====
module rdsc_digit_mem #(
	parameter int DEPTH = rdsc_pkg::VALUE_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  rdsc_pkg::digit_t         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output rdsc_pkg::digit_t         rd_data
);

	rdsc_pkg::digit_t mem_q [DEPTH];
	rdsc_pkg::digit_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_q;

endmodule
